/* hdl/slt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slt_pkg
// Shared types and constants of the sprite layer table.
// ----------------------------------------------------------------------------
package slt_pkg;

  localparam int MAX_LAYERS_DEF = 16;

  localparam int CMD_W       = 3;
  localparam int SLOT_IN_W   = 8;
  localparam int HANDLE_W    = 16;
  localparam int POS_W       = 16;
  localparam int DIM_W       = 13;
  localparam int STATUS_W    = 2;
  localparam int SLOT_OUT_W  = 4;
  localparam int COUNT_OUT_W = 5;
  localparam int CANVAS_W    = 17;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = DIM_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 3'd0,
    CMD_SET    = 3'd1,
    CMD_GET    = 3'd2,
    CMD_MOVE   = 3'd3,
    CMD_REMOVE = 3'd4,
    CMD_COUNT  = 3'd5,
    CMD_BOUNDS = 3'd6
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_HEIGHT = 1'd1;

  typedef struct packed {
    logic init;
    logic accum;
  } bbox_ctl_t;

endpackage

/* hdl/slt_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slt_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module slt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/slt_bbox.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slt_bbox
// Bounding box accumulator: one layer rectangle folded in per step.
// ----------------------------------------------------------------------------
module slt_bbox (
  input  logic                                clk,
  input  slt_pkg::bbox_ctl_t                  ctl,
  input  logic [slt_pkg::DIM_W-1:0]           base_w,
  input  logic [slt_pkg::DIM_W-1:0]           base_h,
  input  logic signed [slt_pkg::POS_W-1:0]    x,
  input  logic signed [slt_pkg::POS_W-1:0]    y,
  input  logic [slt_pkg::DIM_W-1:0]           w,
  input  logic [slt_pkg::DIM_W-1:0]           h,
  output logic signed [slt_pkg::POS_W-1:0]    min_x,
  output logic signed [slt_pkg::POS_W-1:0]    min_y,
  output logic [slt_pkg::CANVAS_W-1:0]        width,
  output logic [slt_pkg::CANVAS_W-1:0]        height
);
  import slt_pkg::*;

  localparam int EXT_W = POS_W + 2;
  localparam int DIF_W = EXT_W + 1;

  logic signed [EXT_W-1:0] max_x;
  logic signed [EXT_W-1:0] max_y;
  logic signed [EXT_W-1:0] right;
  logic signed [EXT_W-1:0] bottom;
  logic signed [DIF_W-1:0] dx;
  logic signed [DIF_W-1:0] dy;

  assign right  = EXT_W'(x) + signed'(EXT_W'(w));
  assign bottom = EXT_W'(y) + signed'(EXT_W'(h));

  always_ff @(posedge clk) begin
    if (ctl.init) begin
      min_x <= '0;
      min_y <= '0;
      max_x <= signed'(EXT_W'(base_w));
      max_y <= signed'(EXT_W'(base_h));
    end else if (ctl.accum) begin
      if (x < min_x) begin
        min_x <= x;
      end
      if (y < min_y) begin
        min_y <= y;
      end
      if (right > max_x) begin
        max_x <= right;
      end
      if (bottom > max_y) begin
        max_y <= bottom;
      end
    end
  end

  assign dx = DIF_W'(max_x) - DIF_W'(min_x);
  assign dy = DIF_W'(max_y) - DIF_W'(min_y);
  assign width  = dx[CANVAS_W-1:0];
  assign height = dy[CANVAS_W-1:0];

endmodule

/* hdl/sprite_layer_table_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_layer_table_unit
// Sprite layer table: add, set, get, move, remove, count and bounding box.
// Set/move/remove/count pass EXEC then RESP; get adds a GET state for the read;
//   add scans for the first free slot in SCAN, bounds walks the slots in WALK.
// One item at a time; add and bounds walk the slots one per cycle, add over
//   the occupied marks, bounds through both RAM read ports and the bbox unit.
// Reset clears the occupied marks, the slot count and the base size; slot
//   contents stay undefined until written.
// ----------------------------------------------------------------------------
module sprite_layer_table_unit #(
  parameter int MAX_LAYERS = slt_pkg::MAX_LAYERS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [slt_pkg::CFG_IDX_W-1:0]       cfg_addr,
  input  logic [slt_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [slt_pkg::CMD_W-1:0]           command,
  input  logic [slt_pkg::SLOT_IN_W-1:0]       layer_slot,
  input  logic [slt_pkg::HANDLE_W-1:0]        image_handle,
  input  logic signed [slt_pkg::POS_W-1:0]    pos_x,
  input  logic signed [slt_pkg::POS_W-1:0]    pos_y,
  input  logic [slt_pkg::DIM_W-1:0]           image_width,
  input  logic [slt_pkg::DIM_W-1:0]           image_height,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [slt_pkg::STATUS_W-1:0]        status,
  output logic [slt_pkg::SLOT_OUT_W-1:0]      slot_index,
  output logic [slt_pkg::HANDLE_W-1:0]        handle_out,
  output logic [slt_pkg::COUNT_OUT_W-1:0]     layer_count,
  output logic signed [slt_pkg::POS_W-1:0]    canvas_min_x,
  output logic signed [slt_pkg::POS_W-1:0]    canvas_min_y,
  output logic [slt_pkg::CANVAS_W-1:0]        canvas_width,
  output logic [slt_pkg::CANVAS_W-1:0]        canvas_height
);
  import slt_pkg::*;

  localparam int IW     = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
  localparam int CW     = $clog2(MAX_LAYERS + 1);
  localparam int TW     = (CW > SLOT_IN_W) ? CW : SLOT_IN_W;
  localparam int INFO_W = HANDLE_W + 2 * DIM_W;
  localparam int PXY_W  = 2 * POS_W;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EXEC = 6'b000010,
    S_SCAN = 6'b000100,
    S_GET  = 6'b001000,
    S_WALK = 6'b010000,
    S_RESP = 6'b100000
  } state_t;

  state_t                  state;
  cmd_t                    cmd_q;
  logic [SLOT_IN_W-1:0]    tgt_q;
  logic [HANDLE_W-1:0]     handle_q;
  logic signed [POS_W-1:0] px_q;
  logic signed [POS_W-1:0] py_q;
  logic [DIM_W-1:0]        w_q;
  logic [DIM_W-1:0]        h_q;
  logic [CW-1:0]           idx;
  logic [CW-1:0]           total;
  logic [MAX_LAYERS-1:0]   used;
  logic                    pend;
  status_t                 res_status;
  logic [IW-1:0]           res_slot;
  logic [HANDLE_W-1:0]     res_handle;
  logic [DIM_W-1:0]        base_w;
  logic [DIM_W-1:0]        base_h;

  logic                    tgt_lt;
  logic                    present;
  logic                    full;
  logic                    idx_lt;
  logic                    idx_used;

  logic                    we_info;
  logic                    we_pos;
  logic [IW-1:0]           waddr;
  logic [IW-1:0]           raddr;
  logic [INFO_W-1:0]       info_rd;
  logic [PXY_W-1:0]        pos_rd;

  bbox_ctl_t               bctl;
  logic signed [POS_W-1:0] bb_min_x;
  logic signed [POS_W-1:0] bb_min_y;
  logic [CANVAS_W-1:0]     bb_w;
  logic [CANVAS_W-1:0]     bb_h;

  assign in_ready = (state == S_IDLE);

  assign tgt_lt   = TW'(tgt_q) < TW'(total);
  assign present  = tgt_lt && used[tgt_q[IW-1:0]];
  assign full     = (total == CW'(MAX_LAYERS));
  assign idx_lt   = idx < total;
  assign idx_used = used[idx[IW-1:0]];

  // RAM port control
  always_comb begin
    we_info = 1'b0;
    we_pos  = 1'b0;
    waddr   = total[IW-1:0];
    raddr   = idx[IW-1:0];
    case (state)
      S_EXEC: begin
        case (cmd_q)
          CMD_SET: begin
            if (tgt_lt) begin
              we_info = 1'b1;
              we_pos  = 1'b1;
              waddr   = tgt_q[IW-1:0];
            end else if (!full) begin
              we_info = 1'b1;
              we_pos  = 1'b1;
            end
          end
          CMD_MOVE: begin
            we_pos = present;
            waddr  = tgt_q[IW-1:0];
          end
          CMD_GET: begin
            raddr = tgt_q[IW-1:0];
          end
          default: begin
          end
        endcase
      end
      S_SCAN: begin
        if (idx_lt) begin
          we_info = !idx_used;
          we_pos  = !idx_used;
          waddr   = idx[IW-1:0];
        end else begin
          we_info = !full;
          we_pos  = !full;
        end
      end
      default: begin
      end
    endcase
  end

  slt_ram #(
    .WIDTH(INFO_W),
    .DEPTH(MAX_LAYERS)
  ) u_info_ram (
    .clk  (clk),
    .we   (we_info),
    .waddr(waddr),
    .wdata({handle_q, w_q, h_q}),
    .raddr(raddr),
    .rdata(info_rd)
  );

  slt_ram #(
    .WIDTH(PXY_W),
    .DEPTH(MAX_LAYERS)
  ) u_pos_ram (
    .clk  (clk),
    .we   (we_pos),
    .waddr(waddr),
    .wdata({px_q, py_q}),
    .raddr(raddr),
    .rdata(pos_rd)
  );

  assign bctl.init  = (state == S_EXEC) && (cmd_q == CMD_BOUNDS);
  assign bctl.accum = (state == S_WALK) && pend;

  slt_bbox u_bbox (
    .clk   (clk),
    .ctl   (bctl),
    .base_w(base_w),
    .base_h(base_h),
    .x     (signed'(pos_rd[PXY_W-1:POS_W])),
    .y     (signed'(pos_rd[POS_W-1:0])),
    .w     (info_rd[2*DIM_W-1:DIM_W]),
    .h     (info_rd[DIM_W-1:0]),
    .min_x (bb_min_x),
    .min_y (bb_min_y),
    .width (bb_w),
    .height(bb_h)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      total     <= '0;
      used      <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
      base_w    <= '0;
      base_h    <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_BASE_WIDTH:  base_w <= cfg_wdata;
          CFG_BASE_HEIGHT: base_h <= cfg_wdata;
          default: begin
          end
        endcase
      end

      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd_q    <= cmd_t'(command);
            tgt_q    <= layer_slot;
            handle_q <= image_handle;
            px_q     <= pos_x;
            py_q     <= pos_y;
            w_q      <= image_width;
            h_q      <= image_height;
            state    <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_status <= ST_OK;
          res_slot   <= '0;
          res_handle <= '0;
          idx        <= '0;
          pend       <= 1'b0;
          state      <= S_RESP;
          case (cmd_q)
            CMD_ADD: begin
              state <= S_SCAN;
            end
            CMD_SET: begin
              if (tgt_lt) begin
                used[tgt_q[IW-1:0]] <= 1'b1;
                res_slot            <= tgt_q[IW-1:0];
              end else if (!full) begin
                used[total[IW-1:0]] <= 1'b1;
                res_slot            <= total[IW-1:0];
                total               <= total + 1'b1;
              end else begin
                res_status <= ST_FULL;
              end
            end
            CMD_GET: begin
              if (present) begin
                state <= S_GET;
              end else begin
                res_status <= ST_MISSING;
              end
            end
            CMD_MOVE: begin
              if (!present) begin
                res_status <= ST_MISSING;
              end
            end
            CMD_REMOVE: begin
              if (tgt_lt) begin
                used[tgt_q[IW-1:0]] <= 1'b0;
              end else begin
                res_status <= ST_MISSING;
              end
            end
            CMD_BOUNDS: begin
              state <= S_WALK;
            end
            default: begin
            end
          endcase
        end
        S_SCAN: begin
          if (idx_lt) begin
            if (!idx_used) begin
              used[idx[IW-1:0]] <= 1'b1;
              res_slot          <= idx[IW-1:0];
              state             <= S_RESP;
            end else begin
              idx <= idx + 1'b1;
            end
          end else begin
            if (!full) begin
              used[total[IW-1:0]] <= 1'b1;
              res_slot            <= total[IW-1:0];
              total               <= total + 1'b1;
            end else begin
              res_status <= ST_FULL;
            end
            state <= S_RESP;
          end
        end
        S_GET: begin
          res_handle <= info_rd[INFO_W-1:2*DIM_W];
          state      <= S_RESP;
        end
        S_WALK: begin
          if (idx_lt) begin
            pend <= idx_used;
            idx  <= idx + 1'b1;
          end else begin
            pend  <= 1'b0;
            state <= S_RESP;
          end
        end
        S_RESP: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            status      <= res_status;
            slot_index  <= SLOT_OUT_W'(res_slot);
            handle_out  <= res_handle;
            layer_count <= COUNT_OUT_W'(total);
            if (cmd_q == CMD_BOUNDS) begin
              canvas_min_x  <= bb_min_x;
              canvas_min_y  <= bb_min_y;
              canvas_width  <= bb_w;
              canvas_height <= bb_h;
            end else begin
              canvas_min_x  <= '0;
              canvas_min_y  <= '0;
              canvas_width  <= '0;
              canvas_height <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* tb/sv/layer_table_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// layer_table_checker
// Watches the command and result channels of the sprite layer table, keeps
// its own copy of the layer table and base size, works out the answer to
// every accepted command and compares each accepted result field by field.
// ----------------------------------------------------------------------------
module layer_table_checker #(
  parameter int MAX_LAYERS = slt_pkg::MAX_LAYERS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [slt_pkg::CFG_IDX_W-1:0]       cfg_addr,
  input  logic [slt_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic [slt_pkg::CMD_W-1:0]           command,
  input  logic [slt_pkg::SLOT_IN_W-1:0]       layer_slot,
  input  logic [slt_pkg::HANDLE_W-1:0]        image_handle,
  input  logic signed [slt_pkg::POS_W-1:0]    pos_x,
  input  logic signed [slt_pkg::POS_W-1:0]    pos_y,
  input  logic [slt_pkg::DIM_W-1:0]           image_width,
  input  logic [slt_pkg::DIM_W-1:0]           image_height,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic [slt_pkg::STATUS_W-1:0]        status,
  input  logic [slt_pkg::SLOT_OUT_W-1:0]      slot_index,
  input  logic [slt_pkg::HANDLE_W-1:0]        handle_out,
  input  logic [slt_pkg::COUNT_OUT_W-1:0]     layer_count,
  input  logic signed [slt_pkg::POS_W-1:0]    canvas_min_x,
  input  logic signed [slt_pkg::POS_W-1:0]    canvas_min_y,
  input  logic [slt_pkg::CANVAS_W-1:0]        canvas_width,
  input  logic [slt_pkg::CANVAS_W-1:0]        canvas_height,
  output int                                  fail_count,
  output int                                  results_pending
);
  import slt_pkg::*;

  typedef struct packed {
    status_t                  status;
    logic [SLOT_OUT_W-1:0]    slot;
    logic [HANDLE_W-1:0]      handle;
    logic [COUNT_OUT_W-1:0]   count;
    logic signed [POS_W-1:0]  min_x;
    logic signed [POS_W-1:0]  min_y;
    logic [CANVAS_W-1:0]      width;
    logic [CANVAS_W-1:0]      height;
  } layer_result_t;

  layer_result_t           layer_results_due[$];
  logic                    layer_used[MAX_LAYERS];
  logic [HANDLE_W-1:0]     layer_handle[MAX_LAYERS];
  logic signed [POS_W-1:0] layer_x[MAX_LAYERS];
  logic signed [POS_W-1:0] layer_y[MAX_LAYERS];
  logic [DIM_W-1:0]        layer_w[MAX_LAYERS];
  logic [DIM_W-1:0]        layer_h[MAX_LAYERS];
  int                      layer_total;
  logic [DIM_W-1:0]        base_w;
  logic [DIM_W-1:0]        base_h;
  int                      mismatches = 0;

  function automatic void store_layer(input int s, input logic [HANDLE_W-1:0] hnd,
                                      input logic signed [POS_W-1:0] x, y,
                                      input logic [DIM_W-1:0] w, h);
    layer_used[s]   = 1'b1;
    layer_handle[s] = hnd;
    layer_x[s]      = x;
    layer_y[s]      = y;
    layer_w[s]      = w;
    layer_h[s]      = h;
  endfunction

  // applies one command to the table copy and returns its result
  function automatic layer_result_t apply_layer_cmd(
    input logic [CMD_W-1:0] cmd, input logic [SLOT_IN_W-1:0] tgt,
    input logic [HANDLE_W-1:0] hnd, input logic signed [POS_W-1:0] x, y,
    input logic [DIM_W-1:0] w, h);
    layer_result_t r;
    int   i, lo_x, lo_y, hi_x, hi_y, rt, bt;
    logic done, present;
    r = '0;
    r.status = ST_OK;
    done = 1'b0;
    present = (int'(tgt) < layer_total) ? layer_used[tgt] : 1'b0;
    case (cmd)
      CMD_ADD, CMD_SET: begin
        if (cmd == CMD_ADD) begin
          for (i = 0; i < layer_total && !done; i++) begin
            if (!layer_used[i]) begin
              store_layer(i, hnd, x, y, w, h);
              r.slot = i[SLOT_OUT_W-1:0];
              done = 1'b1;
            end
          end
        end else if (int'(tgt) < layer_total) begin
          store_layer(int'(tgt), hnd, x, y, w, h);
          r.slot = tgt[SLOT_OUT_W-1:0];
          done = 1'b1;
        end
        if (!done) begin
          if (layer_total >= MAX_LAYERS) begin
            r.status = ST_FULL;
          end else begin
            store_layer(layer_total, hnd, x, y, w, h);
            r.slot = layer_total[SLOT_OUT_W-1:0];
            layer_total++;
          end
        end
      end
      CMD_GET: begin
        if (present) r.handle = layer_handle[tgt];
        else r.status = ST_MISSING;
      end
      CMD_MOVE: begin
        if (present) begin
          layer_x[tgt] = x;
          layer_y[tgt] = y;
        end else begin
          r.status = ST_MISSING;
        end
      end
      CMD_REMOVE: begin
        if (int'(tgt) < layer_total) layer_used[tgt] = 1'b0;
        else r.status = ST_MISSING;
      end
      CMD_BOUNDS: begin
        lo_x = 0;
        lo_y = 0;
        hi_x = int'(base_w);
        hi_y = int'(base_h);
        for (i = 0; i < layer_total; i++) begin
          if (layer_used[i]) begin
            rt = int'(layer_x[i]) + int'(layer_w[i]);
            bt = int'(layer_y[i]) + int'(layer_h[i]);
            if (int'(layer_x[i]) < lo_x) lo_x = int'(layer_x[i]);
            if (int'(layer_y[i]) < lo_y) lo_y = int'(layer_y[i]);
            if (rt > hi_x) hi_x = rt;
            if (bt > hi_y) hi_y = bt;
          end
        end
        r.min_x  = lo_x[POS_W-1:0];
        r.min_y  = lo_y[POS_W-1:0];
        r.width  = 17'(hi_x - lo_x);
        r.height = 17'(hi_y - lo_y);
      end
      default: ;
    endcase
    r.count = layer_total[COUNT_OUT_W-1:0];
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [CANVAS_W-1:0] want,
                                      input logic [CANVAS_W-1:0] seen);
    if (want !== seen) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, seen);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    layer_result_t seen, want;
    if (rst) begin
      layer_results_due.delete();
      for (int i = 0; i < MAX_LAYERS; i++) layer_used[i] = 1'b0;
      layer_total = 0;
      base_w = '0;
      base_h = '0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_BASE_WIDTH:  base_w = cfg_wdata;
          CFG_BASE_HEIGHT: base_h = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        seen.status = status_t'(status);
        seen.slot   = slot_index;
        seen.handle = handle_out;
        seen.count  = layer_count;
        seen.min_x  = canvas_min_x;
        seen.min_y  = canvas_min_y;
        seen.width  = canvas_width;
        seen.height = canvas_height;
        if (layer_results_due.size() == 0) begin
          $display("%0t: result with none due, expected none actual %h", $time, seen);
          mismatches++;
        end else begin
          want = layer_results_due.pop_front();
          check_field("status", want.status, seen.status);
          check_field("slot_index", want.slot, seen.slot);
          check_field("handle_out", want.handle, seen.handle);
          check_field("layer_count", want.count, seen.count);
          check_field("canvas_min_x", want.min_x, seen.min_x);
          check_field("canvas_min_y", want.min_y, seen.min_y);
          check_field("canvas_width", want.width, seen.width);
          check_field("canvas_height", want.height, seen.height);
        end
      end
      if (in_valid && in_ready) begin
        want = apply_layer_cmd(command, layer_slot, image_handle, pos_x, pos_y,
                               image_width, image_height);
        layer_results_due = {layer_results_due, want};
      end
    end
    fail_count      <= mismatches;
    results_pending <= layer_results_due.size();
  end

endmodule

/* tb/sv/tb_sprite_layer_table_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sprite_layer_table_unit
// Drives the sprite layer table with directed corner cases (empty and full
// table, missing slots, extreme positions and sizes, bounds) and then random
// command mixes under several base sizes, with random gaps and back-pressure.
// ----------------------------------------------------------------------------
module tb_sprite_layer_table_unit;
  import slt_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
  localparam int LIMIT_CYCLES = 400000;
  localparam int SETTLE_CYCLES = 24;
  localparam int PHASE_ITEMS = 125;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_addr = '0;
  logic [CFG_DATA_W-1:0]    cfg_wdata = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [CMD_W-1:0]         command = '0;
  logic [SLOT_IN_W-1:0]     layer_slot = '0;
  logic [HANDLE_W-1:0]      image_handle = '0;
  logic signed [POS_W-1:0]  pos_x = '0;
  logic signed [POS_W-1:0]  pos_y = '0;
  logic [DIM_W-1:0]         image_width = '0;
  logic [DIM_W-1:0]         image_height = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [STATUS_W-1:0]      status;
  logic [SLOT_OUT_W-1:0]    slot_index;
  logic [HANDLE_W-1:0]      handle_out;
  logic [COUNT_OUT_W-1:0]   layer_count;
  logic signed [POS_W-1:0]  canvas_min_x;
  logic signed [POS_W-1:0]  canvas_min_y;
  logic [CANVAS_W-1:0]      canvas_width;
  logic [CANVAS_W-1:0]      canvas_height;

  int fail_count;
  int results_pending;
  int cycle_count = 0;
  int idle_max = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  sprite_layer_table_unit u_dut (.*);

  layer_table_checker u_checker (.*);

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result side: random stall before each transfer
  initial begin
    int gap;
    wait (!rst);
    forever begin
      gap = $urandom_range(0, idle_max);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [SLOT_IN_W-1:0] tgt,
                          input logic [HANDLE_W-1:0] hnd,
                          input logic signed [POS_W-1:0] x, y,
                          input logic [DIM_W-1:0] w, h);
    int gap;
    gap = $urandom_range(0, idle_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    command      <= cmd;
    layer_slot   <= tgt;
    image_handle <= hnd;
    pos_x        <= x;
    pos_y        <= y;
    image_width  <= w;
    image_height <= h;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_base(input logic [DIM_W-1:0] bw, input logic [DIM_W-1:0] bh);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_BASE_WIDTH;
    cfg_wdata <= bw;
    @(posedge clk);
    cfg_addr  <= CFG_BASE_HEIGHT;
    cfg_wdata <= bh;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [CMD_W-1:0] rand_cmd();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 20) return CMD_ADD;
    if (pick < 34) return CMD_SET;
    if (pick < 49) return CMD_GET;
    if (pick < 59) return CMD_MOVE;
    if (pick < 77) return CMD_REMOVE;
    if (pick < 82) return CMD_COUNT;
    if (pick < 97) return CMD_BOUNDS;
    return CMD_UNUSED;
  endfunction

  function automatic logic [SLOT_IN_W-1:0] rand_slot();
    if ($urandom_range(0, 99) < 85) return SLOT_IN_W'($urandom_range(0, 17));
    return SLOT_IN_W'($urandom_range(0, 255));
  endfunction

  function automatic logic signed [POS_W-1:0] rand_pos();
    int v;
    case ($urandom_range(0, 3))
      0: v = $urandom;
      1: v = $urandom_range(0, 1) ? 32767 : -32768;
      default: v = $urandom_range(0, 400) - 200;
    endcase
    return v[POS_W-1:0];
  endfunction

  function automatic logic [DIM_W-1:0] rand_dim();
    case ($urandom_range(0, 3))
      0: return DIM_W'($urandom_range(0, 4096));
      1: return DIM_W'($urandom_range(0, 1) ? 4096 : 4095);
      default: return DIM_W'($urandom_range(0, 64));
    endcase
  endfunction

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty table, base size still at reset
    send_cmd(CMD_COUNT, 8'd0, 16'h0000, 16'sd0, 16'sd0, 13'd0, 13'd0);
    send_cmd(CMD_BOUNDS, 8'd0, 16'h0000, 16'sd0, 16'sd0, 13'd0, 13'd0);
    send_cmd(CMD_GET, 8'd0, 16'h0000, 16'sd0, 16'sd0, 13'd0, 13'd0);
    send_cmd(CMD_MOVE, 8'd0, 16'h0000, 16'sd5, 16'sd5, 13'd0, 13'd0);
    send_cmd(CMD_REMOVE, 8'd0, 16'h0000, 16'sd0, 16'sd0, 13'd0, 13'd0);
    send_cmd(CMD_UNUSED, 8'hff, 16'hffff, -16'sd1, -16'sd1, 13'h1fff, 13'h1fff);
    send_cmd(CMD_ADD, 8'd0, 16'hffff, -16'sd32768, 16'sd32767, 13'd4096, 13'd0);
    send_cmd(CMD_ADD, 8'd0, 16'h0000, 16'sd32767, -16'sd32768, 13'd0, 13'd4096);
    send_cmd(CMD_SET, 8'd200, 16'h1234, 16'sd0, 16'sd0, 13'd4095, 13'd4095);
    send_cmd(CMD_BOUNDS, 8'd0, 16'h0000, 16'sd0, 16'sd0, 13'd0, 13'd0);
    // hole in slot 0: empty-slot get/move, double remove, refill by add
    send_cmd(CMD_REMOVE, 8'd0, 16'h0000, 16'sd0, 16'sd0, 13'd0, 13'd0);
    send_cmd(CMD_GET, 8'd0, 16'h0000, 16'sd0, 16'sd0, 13'd0, 13'd0);
    send_cmd(CMD_MOVE, 8'd0, 16'h0000, 16'sd9, 16'sd9, 13'd0, 13'd0);
    send_cmd(CMD_REMOVE, 8'd0, 16'h0000, 16'sd0, 16'sd0, 13'd0, 13'd0);
    send_cmd(CMD_ADD, 8'd9, 16'h5a5a, -16'sd100, 16'sd50, 13'd20, 13'd30);
    send_cmd(CMD_MOVE, 8'd1, 16'h0000, -16'sd1, -16'sd1, 13'd0, 13'd0);
    send_cmd(CMD_GET, 8'd2, 16'h0000, 16'sd0, 16'sd0, 13'd0, 13'd0);

    drain_results();
    write_base(13'd4096, 13'd4096);
    send_cmd(CMD_BOUNDS, 8'd0, 16'h0000, 16'sd0, 16'sd0, 13'd0, 13'd0);
    // fill up to a full table, then appends must fail
    repeat (13) send_cmd(CMD_ADD, 8'd0, 16'($urandom), rand_pos(), rand_pos(),
                         rand_dim(), rand_dim());
    send_cmd(CMD_ADD, 8'd0, 16'hbeef, 16'sd1, 16'sd1, 13'd1, 13'd1);
    send_cmd(CMD_SET, 8'd16, 16'hbeef, 16'sd1, 16'sd1, 13'd1, 13'd1);
    send_cmd(CMD_SET, 8'd15, 16'hc0de, 16'sd300, -16'sd300, 13'd4096, 13'd4096);
    send_cmd(CMD_REMOVE, 8'd16, 16'h0000, 16'sd0, 16'sd0, 13'd0, 13'd0);
    send_cmd(CMD_REMOVE, 8'd7, 16'h0000, 16'sd0, 16'sd0, 13'd0, 13'd0);
    send_cmd(CMD_ADD, 8'd0, 16'h7777, 16'sd7, 16'sd7, 13'd7, 13'd7);
    send_cmd(CMD_BOUNDS, 8'd0, 16'h0000, 16'sd0, 16'sd0, 13'd0, 13'd0);

    for (int phase = 0; phase < 4; phase++) begin
      drain_results();
      case (phase)
        0: write_base(13'd0, 13'd0);
        1: write_base(13'd4096, 13'd4096);
        2: write_base(13'd1, 13'd4095);
        default: write_base(DIM_W'($urandom_range(0, 4096)), DIM_W'($urandom_range(0, 4096)));
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 40 == 0) begin
          case ($urandom_range(0, 2))
            0: idle_max = 0;
            1: idle_max = 3;
            default: idle_max = 14;
          endcase
        end
        if ($urandom_range(0, 49) == 0) drain_results();
        send_cmd(rand_cmd(), rand_slot(), 16'($urandom), rand_pos(), rand_pos(),
                 rand_dim(), rand_dim());
      end
    end

    drain_results();
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
